### src/assert_macros.svh
// Assertion macros shared by the tour block modules.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### src/bnnt_pkg.sv
// Package for the bitmap nearest-neighbor tour block.
// Holds payload structs, state enum and reset/size constants; no dependencies.
package bnnt_pkg;

    typedef struct packed {
        logic [7:0] bitmap_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] point_x;
        logic [7:0] point_y;
        logic       last_point;
        logic       overflowed;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PIXEL,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    localparam logic [8:0] ROW_WIDTH_RESET = 9'd16;
    localparam int unsigned PIXELS_PER_WORD = 8;

endpackage

### src/bnnt_lane.sv
// One search lane: squared distance from the current point to one stored point.
// Depends on bnnt_pkg only through the common import convention.
module bnnt_lane
    import bnnt_pkg::*;
#(
    parameter int COORD_BITS = 8
)
(
    input  logic                      clk,
    input  logic [COORD_BITS-1:0]     cur_x,
    input  logic [COORD_BITS-1:0]     cur_y,
    input  logic [COORD_BITS-1:0]     pt_x,
    input  logic [COORD_BITS-1:0]     pt_y,
    input  logic                      live,
    output logic                      live_q,
    output logic [2*COORD_BITS:0]     dist_sq
);
    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [2*COORD_BITS-1:0] sq_x;
    logic [2*COORD_BITS-1:0] sq_y;
    logic [2*COORD_BITS:0]   dist_reg;
    logic                    live_reg;

    // form absolute differences
    assign dx = (cur_x > pt_x) ? cur_x - pt_x : pt_x - cur_x;
    assign dy = (cur_y > pt_y) ? cur_y - pt_y : pt_y - cur_y;

    // square at full product width
    assign sq_x = dx * dx;
    assign sq_y = dy * dy;

    // register the sum of squares
    always_ff @(posedge clk)
    begin
        dist_reg <= {1'b0, sq_x} + {1'b0, sq_y};
        live_reg <= live;
    end

    assign dist_sq = dist_reg;
    assign live_q  = live_reg;
endmodule

### src/bnnt_merge.sv
// Merge stage: picks the lowest-index lane holding the minimum distance.
// Depends on bnnt_pkg; combines registered lane outputs.
module bnnt_merge
    import bnnt_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 8
)
(
    input  logic [MAX_POINTS-1:0]                     live,
    input  logic [MAX_POINTS-1:0][2*COORD_BITS:0]     dist_sq,
    output logic                                      found,
    output logic [$clog2(MAX_POINTS)-1:0]             best
);
    localparam int IDX_BITS = $clog2(MAX_POINTS);
    localparam int LEAVES   = 1 << IDX_BITS;

    logic [2*LEAVES-1:1]                 node_live;
    logic [2*LEAVES-1:1][2*COORD_BITS:0] node_d;
    logic [2*LEAVES-1:1][IDX_BITS-1:0]   node_idx;
    logic                                take_right;

    // reduce lanes pairwise; the left (lower index) side wins ties
    always_comb
    begin
        node_live  = '0;
        node_d     = '0;
        node_idx   = '0;
        take_right = 1'b0;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            node_live[LEAVES+i] = live[i];
            node_d[LEAVES+i]    = dist_sq[i];
        end
        for (int i = 0; i < LEAVES; i++)
            node_idx[LEAVES+i] = IDX_BITS'(i);
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            take_right   = node_live[2*n+1]
                           && (!node_live[2*n] || node_d[2*n+1] < node_d[2*n]);
            node_live[n] = node_live[2*n] || node_live[2*n+1];
            node_d[n]    = take_right ? node_d[2*n+1] : node_d[2*n];
            node_idx[n]  = take_right ? node_idx[2*n+1] : node_idx[2*n];
        end
    end

    assign found = node_live[1];
    assign best  = node_idx[1];
endmodule

### src/bitmap_nearest_neighbor_tour.sv
// Bitmap nearest-neighbor tour: collects set pixels of a bitmap and emits a greedy tour.
// Depends on bnnt_pkg, bnnt_lane, bnnt_merge and assert_macros.svh.
//
// A byte is accepted in ST_LOAD, then stepped through ST_PIXEL one bit at a time
// by the single pixel path into the point store; the next byte is taken only
// after its last bit. The origin is emitted with the last pixel of the last
// byte; each further tour point passes through ST_SEARCH, which loads the lane
// distance registers, then ST_EMIT, which emits it. Results appear as one-cycle
// strobes on result_valid and cannot be stalled; busy drops in the cycle the
// final point is on the result port. The store then returns to its cleared state.
`include "assert_macros.svh"
module bitmap_nearest_neighbor_tour
    import bnnt_pkg::*;
#(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_word_t   item,
    output logic       result_valid,
    output out_word_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data
);
    localparam int IDX_BITS = $clog2(MAX_POINTS);
    localparam int CNT_BITS = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(MAX_POINTS);
    localparam logic [8:0] COORD_MAX = (COORD_BITS >= 9) ? 9'd511 : 9'((1 << COORD_BITS) - 1);

    state_t                state_reg, state_next;
    logic [8:0]            row_width_reg;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic [2:0]            bit_reg, bit_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [8:0]            col_reg, col_next;
    logic [7:0]            row_reg, row_next;
    logic                  first_reg, first_next;
    logic                  drop_reg, drop_next;
    logic [MAX_POINTS-1:0] visited_reg, visited_next;
    logic [IDX_BITS-1:0]   cur_reg, cur_next;
    logic [CNT_BITS-1:0]   step_reg, step_next;
    logic [MAX_POINTS-1:0][COORD_BITS-1:0] xs_reg, ys_reg;

    logic [8:0]            width;
    logic                  pix;
    logic                  wr_en;
    logic [COORD_BITS-1:0] wr_x, wr_y;
    logic [MAX_POINTS-1:0] live;
    logic [MAX_POINTS-1:0] live_q;
    logic [MAX_POINTS-1:0][2*COORD_BITS:0] dist_sq;
    logic                  found;
    logic [IDX_BITS-1:0]   best;
    logic                  emit_valid_next;
    out_word_t             emit_next;
    logic                  res_valid_reg;
    out_word_t             res_reg;

    assign cfg_ready = (state_reg == ST_LOAD);
    assign busy      = (state_reg != ST_LOAD);
    assign width     = (row_width_reg == 9'd0 || row_width_reg > 9'd256) ? 9'd256 : row_width_reg;
    assign pix       = byte_reg[bit_reg];

    // hold the row width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_width_reg <= ROW_WIDTH_RESET;
        else if (cfg_valid && cfg_ready)
            row_width_reg <= cfg_data;
    end

    // write the point store; entry 0 stays the origin
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            xs_reg[count_reg[IDX_BITS-1:0]] <= wr_x;
            ys_reg[count_reg[IDX_BITS-1:0]] <= wr_y;
        end
    end

    // lanes: one per stored point
    for (genvar g = 0; g < MAX_POINTS; g++)
    begin : g_lane
        logic [COORD_BITS-1:0] lx, ly;
        assign lx = (g == 0) ? '0 : xs_reg[g];
        assign ly = (g == 0) ? '0 : ys_reg[g];
        assign live[g] = !visited_reg[g] && (CNT_BITS'(g) < count_reg);
        bnnt_lane #(.COORD_BITS(COORD_BITS)) u_lane (
            .clk     (clk),
            .cur_x   ((cur_reg == '0) ? '0 : xs_reg[cur_reg]),
            .cur_y   ((cur_reg == '0) ? '0 : ys_reg[cur_reg]),
            .pt_x    (lx),
            .pt_y    (ly),
            .live    (live[g]),
            .live_q  (live_q[g]),
            .dist_sq (dist_sq[g])
        );
    end

    bnnt_merge #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_merge (
        .live    (live_q),
        .dist_sq (dist_sq),
        .found   (found),
        .best    (best)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            bit_reg       <= '0;
            count_reg     <= CNT_BITS'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            first_reg     <= 1'b1;
            drop_reg      <= 1'b0;
            visited_reg   <= '0;
            cur_reg       <= '0;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            count_reg     <= count_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            first_reg     <= first_next;
            drop_reg      <= drop_next;
            visited_reg   <= visited_next;
            cur_reg       <= cur_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            res_valid_reg <= emit_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        res_reg  <= emit_next;
    end

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        bit_next        = bit_reg;
        count_next      = count_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        first_next      = first_reg;
        drop_next       = drop_reg;
        visited_next    = visited_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        wr_en           = 1'b0;
        wr_x            = (col_reg > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(col_reg);
        wr_y            = ({1'b0, row_reg} > COORD_MAX) ? COORD_BITS'(COORD_MAX)
                                                         : COORD_BITS'(row_reg);
        emit_valid_next = 1'b0;
        emit_next       = res_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    byte_next  = item.bitmap_byte;
                    last_next  = item.last_byte;
                    bit_next   = '0;
                    state_next = ST_PIXEL;
                end
            end
            ST_PIXEL:
            begin
                // take one pixel
                if (pix && !first_reg)
                begin
                    if (count_reg < FULL)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                        drop_next = 1'b1;
                end
                first_next = 1'b0;
                if (col_reg + 9'd1 >= width)
                begin
                    col_next = '0;
                    if (row_reg != 8'd255)
                        row_next = row_reg + 1'b1;
                end
                else
                    col_next = col_reg + 1'b1;
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 3'(PIXELS_PER_WORD - 1))
                begin
                    if (last_reg)
                    begin
                        // emit origin first
                        emit_valid_next      = 1'b1;
                        emit_next.point_x    = '0;
                        emit_next.point_y    = '0;
                        emit_next.last_point = (count_next == CNT_BITS'(1));
                        emit_next.overflowed = drop_next;
                        visited_next         = MAX_POINTS'(1);
                        cur_next             = '0;
                        step_next            = CNT_BITS'(1);
                        state_next           = (count_next == CNT_BITS'(1)) ? ST_LOAD : ST_SEARCH;
                    end
                    else
                        state_next = ST_LOAD;
                end
            end
            ST_SEARCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // advance to the nearest unvisited point
                emit_valid_next      = 1'b1;
                emit_next.point_x    = 8'(xs_reg[best]);
                emit_next.point_y    = 8'(ys_reg[best]);
                emit_next.last_point = (step_reg + 1'b1 == count_reg);
                emit_next.overflowed = drop_reg;
                cur_next             = best;
                visited_next         = visited_reg | (MAX_POINTS'(1) << best);
                step_next            = step_reg + 1'b1;
                state_next           = (step_reg + 1'b1 == count_reg) ? ST_LOAD : ST_SEARCH;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        // clear the image after the final point
        if (emit_valid_next && emit_next.last_point)
        begin
            count_next = CNT_BITS'(1);
            col_next   = '0;
            row_next   = '0;
            first_next = 1'b1;
            drop_next  = 1'b0;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `ASSERT_IMPLIES(a_found_in_emit, clk, rst_n, state_reg == ST_EMIT, found)
    `ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, count_reg != '0 && count_reg <= FULL)
    `ASSERT_IMPLIES(a_last_idle, clk, rst_n, res_valid_reg && res_reg.last_point, !busy)
    `ASSERT_IMPLIES(a_cfg_idle, clk, rst_n, cfg_valid && cfg_ready, state_reg == ST_LOAD)
endmodule
